// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the bounded deque bag unit.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// Package of the bounded deque bag unit: transaction structs, command and
// status codes, sequencer states. No dependencies.
package bdq_pkg;

    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] item_value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     empty_flag;
        logic                     found_flag;
        logic [STATUS_W-1:0]      status;
    } out_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_SHIFT,
        ST_RD_FRONT,
        ST_RD_BACK,
        ST_RD_LAST,
        ST_DONE
    } seq_state_t;

endpackage

// File: rtl/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/bdq_core.sv
// Sequencer and datapath of the bounded deque bag: circular store pointers,
// one-entry-per-cycle search and gap closing, front/back refresh.
// Depends on bdq_pkg, bdq_ram and assert_macros.svh.
`include "assert_macros.svh"

module bdq_core
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  in_t        in_item,
    input  logic       take,
    output core_stat_t stat,
    output out_t       result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, pos};
        if (sum >= (CW + 1)'(DEPTH))
        begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    seq_state_t               state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            rd_pos_reg, rd_pos_next;
    logic                     chk_valid_reg, chk_valid_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [DATA_W-1:0]        val_reg, val_next;
    logic                     found_reg, found_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [DATA_W-1:0] front_reg, front_next;
    logic signed [DATA_W-1:0] back_reg, back_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              is_full;
    logic              is_empty;
    logic              is_search;
    logic              match;
    logic              more_rd;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign is_full   = (count_reg >= FULL_COUNT);
    assign is_empty  = (count_reg == '0);
    assign is_search = (cmd_reg == CMD_CONTAINS) || (cmd_reg == CMD_REMOVE);
    assign match     = chk_valid_reg && (ram_rdata == val_reg);
    assign more_rd   = (rd_pos_reg < count_reg);
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (is_search && !is_empty)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    state_next = (cmd_reg == CMD_REMOVE) ? ST_SHIFT : ST_RD_FRONT;
                end
                else if (!more_rd)
                begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_SHIFT:
            begin
                if (!more_rd && !chk_valid_reg)
                begin
                    state_next = ST_RD_FRONT;
                end
            end
            ST_RD_FRONT:
            begin
                state_next = is_empty ? ST_DONE : ST_RD_BACK;
            end
            ST_RD_BACK:
            begin
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        rd_pos_next    = rd_pos_reg;
        chk_valid_next = chk_valid_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = val_reg;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = in_item.cmd;
                    val_next    = in_item.item_value;
                    found_next  = 1'b0;
                    status_next = STATUS_OK;
                end
            end
            ST_EXEC:
            begin
                rd_pos_next    = '0;
                chk_valid_next = 1'b0;
                case (cmd_reg) inside
                    CMD_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            head_next  = head_dec;
                            ram_we     = 1'b1;
                            ram_waddr  = head_dec;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = slot_of(head_reg, count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            head_next  = head_inc;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    found_next     = 1'b1;
                    chk_valid_next = 1'b0;
                end
                else if (more_rd)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = slot_of(head_reg, rd_pos_reg);
                    rd_pos_next    = rd_pos_reg + CW'(1);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end
            ST_SHIFT:
            begin
                // move the entry read last cycle up by one position
                if (chk_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(head_reg, rd_pos_reg - CW'(2));
                    ram_wdata = ram_rdata;
                end
                if (more_rd)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = slot_of(head_reg, rd_pos_reg);
                    rd_pos_next    = rd_pos_reg + CW'(1);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            ST_RD_FRONT:
            begin
                if (is_empty)
                begin
                    front_next = '0;
                    back_next  = '0;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = head_reg;
                end
            end
            ST_RD_BACK:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot_of(head_reg, count_reg - CW'(1));
                front_next = ram_rdata;
            end
            ST_RD_LAST:
            begin
                back_next = ram_rdata;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg <= rd_pos_next;
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        front_reg  <= front_next;
        back_reg   <= back_next;
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

    assign result.front_value = front_reg;
    assign result.back_value  = back_reg;
    assign result.entry_count = count_ext[COUNT_OUT_W-1:0];
    assign result.empty_flag  = is_empty;
    assign result.found_flag  = found_reg;
    assign result.status      = status_reg;

    `ASSERT_CLK(a_count_bound, count_reg <= FULL_COUNT, "stored count exceeds depth")
    `ASSERT_CLK(a_start_idle, start |-> (state_reg == ST_IDLE), "transaction started while busy")
    `ASSERT_CLK(a_empty_zero, ((state_reg == ST_DONE) && is_empty) |-> ((front_reg == '0) && (back_reg == '0)), "empty result with nonzero ends")
    `ASSERT_NEVER(a_refuse_found, (state_reg == ST_DONE) && (status_reg != STATUS_OK) && found_reg, "refused command reports a match")

endmodule

// File: rtl/bounded_deque_bag_unit.sv
// Bounded deque bag unit: up to DEPTH signed 32-bit values kept in order.
// Channel in: in_valid/in_ready carry one command transaction (in_t).
// Channel out: out_valid/out_ready carry one result transaction (out_t).
// Every command gives exactly one result: front and back values, entry
// count, empty flag, found flag and status after the command.
// Push when full or pop when empty changes nothing and reports it in status.
// One command is in work at a time; in_ready is low while it runs.
// Contains compares one stored entry per cycle against the registered
// read of the store. Remove searches the same way and, on a match,
// moves the later entries up one position to close the gap. When the
// store is empty after the command, the front and back values are
// reported as zero without reading the store. The store has a single
// read port. in_ready returns in the same cycle that the result
// appears on out_valid.
// The next command is taken while a finished result waits in the output
// register; if the receiver stalls, the following result waits inside.
// Reset clears the pointers and count: the unit comes up empty and ready.
module bounded_deque_bag_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    core_stat_t stat;
    out_t       result;
    logic       start;
    logic       take;
    logic       out_valid_reg, out_valid_next;
    out_t       out_data_reg;

    assign in_ready = stat.idle;
    assign start    = in_valid && in_ready;
    assign take     = stat.done && (!out_valid_reg || out_ready);

    bdq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_data),
        .take    (take),
        .stat    (stat),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
